/* rtl/core/lpbd_pkg.sv */
// ----------------------------------------------------------------------------
// lpbd_pkg
// Types and constants shared by the length-prefixed bit deserializer modules.
// ----------------------------------------------------------------------------
package lpbd_pkg;

  // Width of the sender identity carried with every bit.
  localparam int unsigned SenderW = 22;
  // Width of a payload byte.
  localparam int unsigned ByteW   = 8;
  // Width of the completed byte counter.
  localparam int unsigned CountW  = 31;
  // Largest message length that is accepted.
  localparam logic [31:0] MaxLength = 32'h7FFF_FFFF;

  // Kind of a result word.
  typedef enum logic [2:0] {
    KIND_HDR_ACK = 3'd0,
    KIND_BYTE    = 3'd1,
    KIND_LAST    = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  // One result word as it travels to the output buffer.
  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data_byte;
    logic [SenderW-1:0] ack_target;
    logic               last;
  } result_t;

endpackage

/* rtl/core/lpbd_core.sv */
// ----------------------------------------------------------------------------
// lpbd_core
// Header and byte assembly: one accepted bit updates the framing state and
// may produce one result word in the same cycle.
// ----------------------------------------------------------------------------
module lpbd_core #(
  parameter int unsigned HEADER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          bit_value_i,
  input  logic [lpbd_pkg::SenderW-1:0]  sender_id_i,
  output logic                          res_valid_o,
  output lpbd_pkg::result_t             res_o
);

  localparam int unsigned CntW = $clog2(HEADER_BITS + 1);
  localparam int unsigned IdxW = $clog2(HEADER_BITS);
  localparam logic [CntW-1:0] HdrLast  = CntW'(HEADER_BITS - 1);
  localparam logic [CntW-1:0] ByteLast = CntW'(lpbd_pkg::ByteW - 1);

  logic                          phase_q, phase_d;
  logic [HEADER_BITS-1:0]        hdr_q, hdr_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [lpbd_pkg::ByteW-1:0]    byte_q, byte_d;
  logic [lpbd_pkg::CountW-1:0]   done_q, done_d;

  logic [HEADER_BITS-1:0]        hdr_next;
  logic [lpbd_pkg::ByteW-1:0]    byte_next;
  logic [lpbd_pkg::CountW-1:0]   done_inc;
  logic [31:0]                   hdr_next_ext;
  logic [31:0]                   hdr_len;

  // Bit insertion into the header and into the byte under assembly.
  always_comb begin
    hdr_next = hdr_q;
    hdr_next[cnt_q[IdxW-1:0]] = hdr_q[cnt_q[IdxW-1:0]] | bit_value_i;
    byte_next = byte_q;
    byte_next[cnt_q[2:0]] = byte_q[cnt_q[2:0]] | bit_value_i;
  end

  assign hdr_next_ext = 32'(hdr_next);
  assign hdr_len      = 32'(hdr_q);
  assign done_inc     = done_q + lpbd_pkg::CountW'(1);

  // Framing state update and result selection.
  always_comb begin
    phase_d          = phase_q;
    hdr_d            = hdr_q;
    cnt_d            = cnt_q;
    byte_d           = byte_q;
    done_d           = done_q;
    res_valid_o      = 1'b0;
    res_o.kind       = lpbd_pkg::KIND_BYTE;
    res_o.data_byte  = '0;
    res_o.ack_target = '0;
    res_o.last       = 1'b0;
    if (accept_i) begin
      if (!phase_q) begin
        hdr_d = hdr_next;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == HdrLast) begin
          res_valid_o      = 1'b1;
          res_o.ack_target = sender_id_i;
          cnt_d            = '0;
          byte_d           = '0;
          done_d           = '0;
          priority if (hdr_next_ext == 32'd0) begin
            // An empty message completes at once.
            hdr_d      = '0;
            res_o.kind = lpbd_pkg::KIND_EMPTY;
            res_o.last = 1'b1;
          end else if (hdr_next_ext > lpbd_pkg::MaxLength) begin
            hdr_d      = '0;
            res_o.kind = lpbd_pkg::KIND_ERROR;
            res_o.last = 1'b1;
          end else begin
            phase_d    = 1'b1;
            res_o.kind = lpbd_pkg::KIND_HDR_ACK;
          end
        end
      end else begin
        byte_d = byte_next;
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == ByteLast) begin
          res_valid_o     = 1'b1;
          res_o.data_byte = byte_next;
          cnt_d           = '0;
          byte_d          = '0;
          done_d          = done_inc;
          if ({1'b0, done_inc} >= hdr_len) begin
            // Final byte of the message: back to header phase.
            phase_d          = 1'b0;
            hdr_d            = '0;
            done_d           = '0;
            res_o.kind       = lpbd_pkg::KIND_LAST;
            res_o.ack_target = sender_id_i;
            res_o.last       = 1'b1;
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      hdr_q   <= '0;
      cnt_q   <= '0;
      byte_q  <= '0;
      done_q  <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      cnt_q   <= cnt_d;
      byte_q  <= byte_d;
      done_q  <= done_d;
    end
  end

endmodule

/* rtl/core/lpbd_out_buf.sv */
// ----------------------------------------------------------------------------
// lpbd_out_buf
// Output register with a skid entry, so the input stall is registered and
// a result is never dropped while the consumer stalls.
// ----------------------------------------------------------------------------
module lpbd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lpbd_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpbd_pkg::result_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  lpbd_pkg::result_t out_data_q, out_data_d;
  lpbd_pkg::result_t skid_data_q, skid_data_d;
  logic              out_ready;

  assign out_ready = !out_valid_q || !out_stall_i;

  // Refill the output register from the skid entry first, then from a push.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/core/length_prefixed_bit_deserializer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_bit_deserializer
// Deframes a serial bit stream: a length header, LSB first, then that many
// payload bytes, each LSB first.
// ----------------------------------------------------------------------------
// The block takes one bit word per clock while in_stall_o is low, handles
// each bit in the cycle it is accepted and registers each result word in
// the output buffer before it reaches the output. A header of HEADER_BITS
// bits is gathered first and acknowledged to the sender (kind 0); a header
// of zero ends the message at once (kind 3) and a header above 2^31-1
// reports a length error (kind 4). Payload bytes then come out as kind 1,
// and the byte that reaches the length as kind 2 with last set, after
// which the next bit starts a new header. Acknowledges go to the sender of
// the bit that causes them. The output side holds two result words (output
// register plus skid entry), so the input stalls only when both are
// occupied; with no downstream stall the rate is one bit per clock.
module length_prefixed_bit_deserializer #(
  parameter int unsigned HEADER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          bit_value_i,
  input  logic [lpbd_pkg::SenderW-1:0]  sender_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    kind_o,
  output logic [lpbd_pkg::ByteW-1:0]    data_byte_o,
  output logic [lpbd_pkg::SenderW-1:0]  ack_target_o,
  output logic                          last_o
);

  logic              accept;
  logic              full;
  logic              res_valid;
  lpbd_pkg::result_t res;
  lpbd_pkg::result_t out_data;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Framing logic.
  lpbd_core #(
    .HEADER_BITS (HEADER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .bit_value_i (bit_value_i),
    .sender_id_i (sender_id_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result buffering toward the consumer.
  lpbd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign kind_o       = out_data.kind;
  assign data_byte_o  = out_data.data_byte;
  assign ack_target_o = out_data.ack_target;
  assign last_o       = out_data.last;

endmodule
